@@ src/lcg_pkg.sv @@
// ----------------------------------------------------------------------------
// lcg_pkg
// types and constants shared by the combination generator modules
// ----------------------------------------------------------------------------
package lcg_pkg;

    localparam int CMD_W      = 2;
    localparam int EIDX_W     = 5;
    localparam int VALUE_BITS = 16;
    localparam int SLOT_W     = 5;
    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 1;

    // input command codes
    typedef enum logic [CMD_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_NEXT    = 2'd2
    } lcg_op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_SIZE   = 1'b0,
        CFG_PICK_COUNT = 1'b1
    } lcg_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_EMIT,
        ST_EXH
    } lcg_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [EIDX_W-1:0]     element_index;
        logic [VALUE_BITS-1:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic                  status;
        logic [SLOT_W-1:0]     slot;
        logic [VALUE_BITS-1:0] value;
        logic                  last_of_run;
        logic                  final_combination;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic do_load;
        logic do_restart;
        logic start_scan;
        logic scan_step;
        logic emit_fetch;
        logic emit_out;
        logic exh_out;
    } lcg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic exhausted;
        logic at_end;
    } lcg_sts_t;

endpackage

@@ src/lcg_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcg_ctrl
// sequencer: scan pass over the indices, then fetch and emit per element
// ----------------------------------------------------------------------------
module lcg_ctrl
    import lcg_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic [CMD_W-1:0] s_command,
    output logic             s_ready,
    input  lcg_sts_t         sts,
    output lcg_cmd_t         cmd
);

    lcg_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_command == OP_NEXT) begin
                    state_next = sts.exhausted ? ST_EXH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.at_end) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_EMIT;
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = sts.at_end ? ST_IDLE : ST_FETCH;
                end
            end
            ST_EXH: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_command)
                        OP_LOAD:    cmd.do_load    = 1'b1;
                        OP_RESTART: cmd.do_restart = 1'b1;
                        OP_NEXT:    cmd.start_scan = !sts.exhausted;
                        default:    cmd = '0;
                    endcase
                end
            end
            ST_SCAN:  cmd.scan_step  = 1'b1;
            ST_FETCH: cmd.emit_fetch = 1'b1;
            ST_EMIT:  cmd.emit_out   = sts.out_free;
            ST_EXH:   cmd.exh_out    = sts.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

@@ src/lcg_dpath.sv @@
// ----------------------------------------------------------------------------
// lcg_dpath
// index and element memories, scan logic, successor update, result register
// ----------------------------------------------------------------------------
module lcg_dpath
    import lcg_pkg::*;
#(
    parameter int MAX_ELEMENTS = 32,
    parameter int MAX_PICK     = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  in_item_t         s_data,
    input  logic [CFG_W-1:0] set_size,
    input  logic [CFG_W-1:0] pick_count,
    input  lcg_cmd_t         cmd,
    output lcg_sts_t         sts,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    localparam int IMAX = (MAX_ELEMENTS > MAX_PICK) ? MAX_ELEMENTS : MAX_PICK;
    localparam int IW   = $clog2(IMAX + 1);
    localparam int PW   = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
    localparam int EW   = $clog2(MAX_ELEMENTS);
    localparam int CW   = (IW + 1 > CFG_W + 1) ? IW + 1 : CFG_W + 1;

    // memories
    logic [VALUE_BITS-1:0] tbl_mem [MAX_ELEMENTS];
    logic [IW-1:0]         idx_mem [MAX_PICK];
    logic [MAX_PICK-1:0]   idx_vld_reg;

    logic [IW-1:0]         idx_rd_reg;
    logic                  idx_rd_vld_reg;
    logic [PW-1:0]         idx_rd_addr_reg;
    logic [VALUE_BITS-1:0] tbl_rd_reg;
    logic                  tbl_ok_reg;

    logic [PW-1:0]         pos_reg;
    logic                  found_reg;
    logic                  ge_reg;
    logic                  final_reg;
    logic [IW-1:0]         run_reg;
    logic                  exhausted_reg;
    logic                  m_valid_reg;
    out_item_t             m_data_reg;

    // effective n, m and the limit n - m + 1
    logic [CW-1:0] n_raw, m_raw, m_tmp, n_eff, m_eff, lim, m_last, addr_w;

    always_comb begin
        n_raw = CW'(set_size);
        m_raw = CW'(pick_count);
        n_eff = (n_raw == '0) ? CW'(1) : n_raw;
        if (n_eff > CW'(MAX_ELEMENTS)) begin
            n_eff = CW'(MAX_ELEMENTS);
        end
        m_tmp = (m_raw == '0) ? CW'(1) : m_raw;
        if (m_tmp > CW'(MAX_PICK)) begin
            m_tmp = CW'(MAX_PICK);
        end
        m_eff  = (m_tmp > n_eff) ? n_eff : m_tmp;
        lim    = n_eff - m_eff + CW'(1);
        m_last = m_eff - CW'(1);
        addr_w = CW'(idx_rd_addr_reg);
    end

    // index read data; an entry not yet written holds its restart value
    logic [IW-1:0]  idx_val;
    logic           at_end, hit, ge, tbl_ok, upd;
    logic [IW-1:0]  new_val;
    logic [EW-1:0]  tbl_addr;

    always_comb begin
        idx_val  = idx_rd_vld_reg ? idx_rd_reg : (IW'(idx_rd_addr_reg) + IW'(1));
        at_end   = (addr_w == m_last);
        hit      = CW'(idx_val) < (lim + addr_w);
        ge       = CW'(idx_val) >= lim;
        tbl_ok   = (idx_val != '0) && (CW'(idx_val) <= CW'(MAX_ELEMENTS));
        tbl_addr = tbl_ok ? EW'(idx_val - IW'(1)) : '0;
        upd      = !final_reg && (idx_rd_addr_reg >= pos_reg);
        new_val  = (idx_rd_addr_reg == pos_reg) ? (idx_val + IW'(1)) : (run_reg + IW'(1));
    end

    // read issue for the index memory
    logic          rd_en;
    logic [PW-1:0] rd_addr;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_rd_addr_reg + PW'(1);
        if (cmd.start_scan) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end else if (cmd.scan_step) begin
            rd_en = 1'b1;
            if (at_end) begin
                rd_addr = '0;
            end
        end else if (cmd.emit_out && !at_end) begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            idx_rd_reg      <= idx_mem[rd_addr];
            idx_rd_vld_reg  <= idx_vld_reg[rd_addr];
            idx_rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_fetch && upd) begin
            idx_mem[idx_rd_addr_reg] <= new_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.do_restart) begin
            idx_vld_reg <= '0;
        end else if (cmd.emit_fetch && upd) begin
            idx_vld_reg[idx_rd_addr_reg] <= 1'b1;
        end
    end

    // element table
    always_ff @(posedge aclk) begin
        if (cmd.do_load && (CW'(s_data.element_index) < CW'(MAX_ELEMENTS))) begin
            tbl_mem[EW'(s_data.element_index)] <= s_data.element_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_fetch) begin
            tbl_rd_reg <= tbl_mem[tbl_addr];
            tbl_ok_reg <= tbl_ok;
            if (upd) begin
                run_reg <= new_val;
            end
        end
    end

    // scan pass: rightmost index that can still advance, final flag
    always_ff @(posedge aclk) begin
        if (cmd.start_scan) begin
            found_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            if (hit) begin
                pos_reg   <= idx_rd_addr_reg;
                found_reg <= 1'b1;
            end
            if (addr_w == '0) begin
                ge_reg <= ge;
            end
            if (at_end) begin
                final_reg <= ((addr_w == '0) ? ge : ge_reg) || !(found_reg || hit);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.do_restart) begin
            exhausted_reg <= 1'b0;
        end else if (cmd.emit_out && at_end && final_reg) begin
            exhausted_reg <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_out || cmd.exh_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_out) begin
            m_data_reg.status            <= 1'b0;
            m_data_reg.slot              <= SLOT_W'(idx_rd_addr_reg);
            m_data_reg.value             <= tbl_ok_reg ? tbl_rd_reg : '0;
            m_data_reg.last_of_run       <= at_end;
            m_data_reg.final_combination <= final_reg;
        end else if (cmd.exh_out) begin
            m_data_reg.status            <= 1'b1;
            m_data_reg.slot              <= '0;
            m_data_reg.value             <= '0;
            m_data_reg.last_of_run       <= 1'b0;
            m_data_reg.final_combination <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.exhausted = exhausted_reg;
    assign sts.at_end    = at_end;

endmodule

@@ src/lex_combination_generator_unit.sv @@
// ----------------------------------------------------------------------------
// lex_combination_generator_unit
// lexicographic k-combination generator with a mapped element table
// ----------------------------------------------------------------------------
// Walks every pick_count-element subset of positions 1..set_size in
// lexicographic order. A load beat writes one slot of the element table, a
// restart beat rewinds the enumeration to positions 1..m, and a next beat
// returns the m table values of the current combination as m result beats
// (slot 0 first, last_of_run on the final one, final_combination on every
// beat of the last subset) and then steps to the successor. Once the last
// combination has gone out, each next beat gets a single result with status
// set until a restart. Loads, restarts and unused codes give no result. A next
// beat first makes one pass over the m stored indices to find the rightmost
// one that can still advance, then each element needs an index read and a
// table read through the single-port memories before its result register is
// loaded. The result register lets the next input beat be taken while the
// last result still waits. Configuration is only to be written while no next
// beat is in progress.
module lex_combination_generator_unit
    import lcg_pkg::*;
#(
    parameter int MAX_ELEMENTS = 32,
    parameter int MAX_PICK     = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input beats
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    // result beats
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // configuration registers, both reset to one
    logic [CFG_W-1:0] set_size_reg, set_size_next;
    logic [CFG_W-1:0] pick_count_reg, pick_count_next;

    lcg_cmd_t cmd;
    lcg_sts_t sts;

    // writes are always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        set_size_next   = set_size_reg;
        pick_count_next = pick_count_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SET_SIZE:   set_size_next   = cfg_data;
                CFG_PICK_COUNT: pick_count_next = cfg_data;
                default: begin
                    set_size_next   = set_size_reg;
                    pick_count_next = pick_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_size_reg   <= CFG_W'(1);
            pick_count_reg <= CFG_W'(1);
        end else begin
            set_size_reg   <= set_size_next;
            pick_count_reg <= pick_count_next;
        end
    end

    // sequencer: decides which datapath action runs each cycle
    lcg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_data.command),
        .s_ready   (s_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // memories, scan and successor logic, result register
    lcg_dpath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_PICK     (MAX_PICK)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_data     (s_data),
        .set_size   (set_size_reg),
        .pick_count (pick_count_reg),
        .cmd        (cmd),
        .sts        (sts),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
